// ===== hdl/mbt_pkg.sv =====
// shared constants, types and helper functions for the maze backtracker
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package mbt_pkg;

  localparam int GRID_MAX = 32;
  localparam int LINE_W   = $clog2(GRID_MAX);
  localparam int NSZ_W    = LINE_W + 1;
  localparam int SQ_W     = 2 * NSZ_W;
  localparam int CELLS    = GRID_MAX * GRID_MAX;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int DEPTH_W  = ADDR_W + 1;
  localparam int CFG_W    = 6;
  localparam int COORD_W  = 5;
  localparam int RAND_W   = 16;
  localparam int CNT_W    = $clog2(RAND_W);
  localparam int EPOCH_W  = 4;

  localparam logic [EPOCH_W-1:0] EPOCH_MAX  = '1;
  localparam logic [CFG_W-1:0]   GRID_RESET = 6'd16;

  typedef enum logic [1:0] {
    WK_RIGHT  = 2'd0,
    WK_BOTTOM = 2'd1,
    WK_ENTRY  = 2'd2,
    WK_EXIT   = 2'd3
  } wall_kind_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_CARVE = 1'b1
  } op_e;

  typedef struct packed {
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr_a;
    logic [ADDR_W-1:0]  rd_addr_b;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [EPOCH_W-1:0] wr_tag;
    logic               clear;
  } vis_req_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] wr_data;
  } stk_req_t;

  typedef struct packed {
    logic              start;
    logic [RAND_W-1:0] dividend;
    logic [NSZ_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [NSZ_W-1:0] rem;
  } mod_rsp_t;

  // register value clamped to the supported grid sizes
  function automatic logic [NSZ_W-1:0] eff_size(input logic [CFG_W-1:0] g);
    logic [NSZ_W-1:0] n;
    if (int'(g) < 2) begin
      n = NSZ_W'(2);
    end else if (int'(g) > GRID_MAX) begin
      n = NSZ_W'(GRID_MAX);
    end else begin
      n = NSZ_W'(g);
    end
    return n;
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [LINE_W-1:0] l,
                                                  input logic [LINE_W-1:0] c);
    return {l, c};
  endfunction

  // 4 == 1 mod 3, so base-4 digits fold down by plain addition
  function automatic logic [1:0] mod3(input logic [RAND_W-1:0] v);
    logic [5:0] s;
    logic [3:0] t;
    s = '0;
    for (int i = 0; i < RAND_W / 2; i++) begin
      s = s + 6'(v[2*i +: 2]);
    end
    t = 4'(s[5:4]) + 4'(s[3:2]) + 4'(s[1:0]);
    if (t >= 4'd6) t = t - 4'd6;
    if (t >= 4'd3) t = t - 4'd3;
    return t[1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/maze_backtracker_step_top.sv =====
// maze backtracker top level: control sequencer, config register, output register
// instantiates mbt_visited, mbt_stack and mbt_mod; uses mbt_pkg
`default_nettype none

// Depth-first maze carver for square grids of 2 to 32 cells per side. Each
// accepted beat yields exactly one result beat. A carve beat takes one more
// look for every dead-end cell popped off the path stack that still has
// cells below it; each look at a stack top costs one stack read and two
// visited-map reads on its two read ports. The exit beat runs a serial
// remainder. Visited cells are marked with a 4-bit maze tag, so a start
// only bumps the tag; after reset, and on every fifteenth start, the visited
// map is swept clean at one cell per cycle with the input stalled. Write
// grid_size only while no beat is in flight.
module maze_backtracker_step_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [mbt_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          op_i,
  input  wire logic [4:0]                    start_column_i,
  input  wire logic [mbt_pkg::RAND_W-1:0]    choice_random_i,
  input  wire logic [mbt_pkg::RAND_W-1:0]    exit_random_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [mbt_pkg::COORD_W-1:0]        wall_line_o,
  output logic [mbt_pkg::COORD_W-1:0]        wall_column_o,
  output logic [1:0]                         wall_kind_o,
  output logic                               opened_o,
  output logic                               finished_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_START, ST_TOP, ST_NB1, ST_NB2, ST_EXIT, ST_RESP
  } state_e;

  typedef enum logic [1:0] {DIR_UP, DIR_RIGHT, DIR_LEFT, DIR_DOWN} dir_e;

  state_e                         state_q;
  logic [mbt_pkg::CFG_W-1:0]      grid_q;
  logic [mbt_pkg::EPOCH_W-1:0]    epoch_q;
  logic [mbt_pkg::EPOCH_W-1:0]    epoch_next;
  logic [mbt_pkg::DEPTH_W-1:0]    depth_q;
  logic [mbt_pkg::DEPTH_W-1:0]    vcount_q;
  logic                           done_q;
  logic [mbt_pkg::NSZ_W-1:0]      n_q;
  logic [mbt_pkg::LINE_W-1:0]     sc_q;
  logic [mbt_pkg::RAND_W-1:0]     cr_q;
  logic [1:0]                     cr_m3_q;
  logic [mbt_pkg::LINE_W-1:0]     cl_q;
  logic [mbt_pkg::LINE_W-1:0]     cc_q;
  logic                           up_q;
  logic                           right_q;

  logic [mbt_pkg::LINE_W-1:0]     res_line_q;
  logic [mbt_pkg::LINE_W-1:0]     res_col_q;
  mbt_pkg::wall_kind_e            res_kind_q;
  logic                           res_opened_q;
  logic                           res_fin_q;

  logic                           out_valid_q;
  logic [mbt_pkg::LINE_W-1:0]     out_line_q;
  logic [mbt_pkg::LINE_W-1:0]     out_col_q;
  mbt_pkg::wall_kind_e            out_kind_q;
  logic                           out_opened_q;
  logic                           out_fin_q;

  mbt_pkg::vis_req_t              vis_req;
  mbt_pkg::stk_req_t              stk_req;
  mbt_pkg::mod_req_t              mod_req;
  mbt_pkg::mod_rsp_t              mod_rsp;
  logic                           clear_busy;
  logic [mbt_pkg::EPOCH_W-1:0]    tag_a;
  logic [mbt_pkg::EPOCH_W-1:0]    tag_b;
  logic [mbt_pkg::ADDR_W-1:0]     stk_top;

  logic                           in_acc;
  logic                           out_free;
  logic                           is_start;
  logic                           vc_full;
  logic                           need_sweep;
  logic [mbt_pkg::NSZ_W-1:0]      n_now;
  logic [mbt_pkg::SQ_W-1:0]       nsq_now;
  logic [mbt_pkg::LINE_W-1:0]     sc_clamp;
  logic [mbt_pkg::LINE_W-1:0]     top_line;
  logic [mbt_pkg::LINE_W-1:0]     top_col;
  logic [mbt_pkg::NSZ_W-1:0]      lx;
  logic [mbt_pkg::NSZ_W-1:0]      cx;
  logic                           up_ok;
  logic                           rt_ok;
  logic                           lf_ok;
  logic                           dn_ok;
  logic [3:0]                     opts;
  logic [2:0]                     k;
  logic [1:0]                     pick;
  logic [1:0]                     seen;
  dir_e                           sel;
  logic [mbt_pkg::LINE_W-1:0]     tgt_line;
  logic [mbt_pkg::LINE_W-1:0]     tgt_col;
  logic [mbt_pkg::LINE_W-1:0]     wl_line;
  logic [mbt_pkg::LINE_W-1:0]     wl_col;
  mbt_pkg::wall_kind_e            wl_kind;
  logic [mbt_pkg::ADDR_W-1:0]     tgt_addr;

  mbt_visited u_visited (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (vis_req),
    .clear_busy_o (clear_busy),
    .rd_tag_a_o   (tag_a),
    .rd_tag_b_o   (tag_b)
  );

  mbt_stack u_stack (
    .clk_i     (clk_i),
    .req_i     (stk_req),
    .rd_data_o (stk_top)
  );

  mbt_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE) || clear_busy;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign is_start    = (op_i == mbt_pkg::OP_START);

  always_comb begin
    n_now      = mbt_pkg::eff_size(grid_q);
    nsq_now    = mbt_pkg::SQ_W'(n_now) * mbt_pkg::SQ_W'(n_now);
    vc_full    = mbt_pkg::SQ_W'(vcount_q) >= nsq_now;
    need_sweep = (epoch_q == mbt_pkg::EPOCH_MAX);
    epoch_next = need_sweep ? mbt_pkg::EPOCH_W'(1) : epoch_q + 1'b1;
    if ({1'b0, start_column_i} > mbt_pkg::NSZ_W'(n_now - 1'b1)) begin
      sc_clamp = mbt_pkg::LINE_W'(n_now - 1'b1);
    end else begin
      sc_clamp = mbt_pkg::LINE_W'(start_column_i);
    end
    top_line = stk_top[mbt_pkg::ADDR_W-1:mbt_pkg::LINE_W];
    top_col  = stk_top[mbt_pkg::LINE_W-1:0];
  end

  // neighbor geometry against the size latched for this beat
  always_comb begin
    lx    = {1'b0, cl_q};
    cx    = {1'b0, cc_q};
    up_ok = (lx != '0) && ((lx - 1'b1) < n_q) && (cx < n_q);
    rt_ok = (lx < n_q) && ((cx + 1'b1) < n_q);
    lf_ok = (cx != '0) && (lx < n_q) && ((cx - 1'b1) < n_q);
    dn_ok = ((lx + 1'b1) < n_q) && (cx < n_q);
    opts  = {dn_ok && (tag_b != epoch_q), lf_ok && (tag_a != epoch_q), right_q, up_q};
    k     = 3'($countones(opts));
    unique case (k)
      3'd2:    pick = {1'b0, cr_q[0]};
      3'd3:    pick = cr_m3_q;
      3'd4:    pick = cr_q[1:0];
      default: pick = 2'd0;
    endcase
    sel  = DIR_UP;
    seen = 2'd0;
    for (int i = 0; i < 4; i++) begin
      if (opts[i]) begin
        if (seen == pick) sel = dir_e'(2'(i));
        seen = seen + 1'b1;
      end
    end
    unique case (sel)
      DIR_UP: begin
        tgt_line = cl_q - 1'b1;
        tgt_col  = cc_q;
        wl_line  = cl_q - 1'b1;
        wl_col   = cc_q;
        wl_kind  = mbt_pkg::WK_BOTTOM;
      end
      DIR_RIGHT: begin
        tgt_line = cl_q;
        tgt_col  = cc_q + 1'b1;
        wl_line  = cl_q;
        wl_col   = cc_q;
        wl_kind  = mbt_pkg::WK_RIGHT;
      end
      DIR_LEFT: begin
        tgt_line = cl_q;
        tgt_col  = cc_q - 1'b1;
        wl_line  = cl_q;
        wl_col   = cc_q - 1'b1;
        wl_kind  = mbt_pkg::WK_RIGHT;
      end
      DIR_DOWN: begin
        tgt_line = cl_q + 1'b1;
        tgt_col  = cc_q;
        wl_line  = cl_q;
        wl_col   = cc_q;
        wl_kind  = mbt_pkg::WK_BOTTOM;
      end
      default: begin
        tgt_line = cl_q;
        tgt_col  = cc_q;
        wl_line  = cl_q;
        wl_col   = cc_q;
        wl_kind  = mbt_pkg::WK_RIGHT;
      end
    endcase
    tgt_addr = mbt_pkg::cell_addr(tgt_line, tgt_col);
  end

  // memory requests; the sequencer never reads an entry in the cycle it is written
  always_comb begin
    vis_req.rd_en     = (state_q == ST_TOP) || (state_q == ST_NB1);
    vis_req.rd_addr_a = (state_q == ST_TOP) ? mbt_pkg::cell_addr(top_line - 1'b1, top_col)
                                            : mbt_pkg::cell_addr(cl_q, cc_q - 1'b1);
    vis_req.rd_addr_b = (state_q == ST_TOP) ? mbt_pkg::cell_addr(top_line, top_col + 1'b1)
                                            : mbt_pkg::cell_addr(cl_q + 1'b1, cc_q);
    vis_req.wr_en     = (state_q == ST_START) || ((state_q == ST_NB2) && (k != 3'd0));
    vis_req.wr_addr   = (state_q == ST_START) ? mbt_pkg::cell_addr('0, sc_q) : tgt_addr;
    vis_req.wr_tag    = (state_q == ST_START) ? epoch_next : epoch_q;
    vis_req.clear     = in_acc && is_start && need_sweep;

    stk_req.rd_en   = (in_acc && !is_start && !done_q && !vc_full && (depth_q != '0)) ||
                      ((state_q == ST_NB2) && (k == 3'd0) && (depth_q > mbt_pkg::DEPTH_W'(1)));
    stk_req.rd_addr = (state_q == ST_NB2) ? mbt_pkg::ADDR_W'(depth_q - 2'd2)
                                          : mbt_pkg::ADDR_W'(depth_q - 1'b1);
    stk_req.wr_en   = (state_q == ST_START) ||
                      ((state_q == ST_NB2) && (k != 3'd0) &&
                       (depth_q < mbt_pkg::DEPTH_W'(mbt_pkg::CELLS)));
    stk_req.wr_addr = (state_q == ST_START) ? '0 : depth_q[mbt_pkg::ADDR_W-1:0];
    stk_req.wr_data = (state_q == ST_START) ? mbt_pkg::cell_addr('0, sc_q) : tgt_addr;

    mod_req.start    = in_acc && !is_start && !done_q && vc_full;
    mod_req.dividend = exit_random_i;
    mod_req.divisor  = n_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      grid_q       <= mbt_pkg::GRID_RESET;
      epoch_q      <= '0;
      depth_q      <= '0;
      vcount_q     <= '0;
      done_q       <= 1'b0;
      n_q          <= '0;
      sc_q         <= '0;
      cr_q         <= '0;
      cr_m3_q      <= '0;
      cl_q         <= '0;
      cc_q         <= '0;
      up_q         <= 1'b0;
      right_q      <= 1'b0;
      res_line_q   <= '0;
      res_col_q    <= '0;
      res_kind_q   <= mbt_pkg::WK_RIGHT;
      res_opened_q <= 1'b0;
      res_fin_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_line_q   <= '0;
      out_col_q    <= '0;
      out_kind_q   <= mbt_pkg::WK_RIGHT;
      out_opened_q <= 1'b0;
      out_fin_q    <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) grid_q <= cfg_data_i;
      // a result reload in ST_RESP keeps the output register full
      if (out_valid_q && !out_stall_i && (state_q != ST_RESP)) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            n_q          <= n_now;
            cr_q         <= choice_random_i;
            sc_q         <= sc_clamp;
            res_line_q   <= '0;
            res_col_q    <= '0;
            res_kind_q   <= mbt_pkg::WK_RIGHT;
            res_opened_q <= 1'b0;
            res_fin_q    <= done_q;
            priority if (is_start) begin
              state_q <= need_sweep ? ST_CLEAR : ST_START;
            end else if (done_q) begin
              state_q <= ST_RESP;
            end else if (vc_full) begin
              state_q <= ST_EXIT;
            end else if (depth_q == '0) begin
              state_q <= ST_RESP;
            end else begin
              state_q <= ST_TOP;
            end
          end
        end
        ST_CLEAR: begin
          if (!clear_busy) state_q <= ST_START;
        end
        ST_START: begin
          epoch_q      <= epoch_next;
          depth_q      <= mbt_pkg::DEPTH_W'(1);
          vcount_q     <= mbt_pkg::DEPTH_W'(1);
          done_q       <= 1'b0;
          res_line_q   <= '0;
          res_col_q    <= sc_q;
          res_kind_q   <= mbt_pkg::WK_ENTRY;
          res_opened_q <= 1'b1;
          res_fin_q    <= 1'b0;
          state_q      <= ST_RESP;
        end
        ST_TOP: begin
          cl_q    <= top_line;
          cc_q    <= top_col;
          cr_m3_q <= mbt_pkg::mod3(cr_q);
          state_q <= ST_NB1;
        end
        ST_NB1: begin
          up_q    <= up_ok && (tag_a != epoch_q);
          right_q <= rt_ok && (tag_b != epoch_q);
          state_q <= ST_NB2;
        end
        ST_NB2: begin
          if (k != 3'd0) begin
            if (depth_q < mbt_pkg::DEPTH_W'(mbt_pkg::CELLS)) depth_q <= depth_q + 1'b1;
            vcount_q     <= vcount_q + 1'b1;
            res_line_q   <= wl_line;
            res_col_q    <= wl_col;
            res_kind_q   <= wl_kind;
            res_opened_q <= 1'b1;
            state_q      <= ST_RESP;
          end else begin
            // dead end: pop, then look at the cell below unless the stack is now empty
            depth_q <= depth_q - 1'b1;
            state_q <= (depth_q == mbt_pkg::DEPTH_W'(1)) ? ST_RESP : ST_TOP;
          end
        end
        ST_EXIT: begin
          if (mod_rsp.done) begin
            res_line_q   <= mbt_pkg::LINE_W'(n_q - 1'b1);
            res_col_q    <= mbt_pkg::LINE_W'(mod_rsp.rem);
            res_kind_q   <= mbt_pkg::WK_EXIT;
            res_opened_q <= 1'b1;
            res_fin_q    <= 1'b1;
            done_q       <= 1'b1;
            state_q      <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_line_q   <= res_line_q;
            out_col_q    <= res_col_q;
            out_kind_q   <= res_kind_q;
            out_opened_q <= res_opened_q;
            out_fin_q    <= res_fin_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign wall_line_o   = mbt_pkg::COORD_W'(out_line_q);
  assign wall_column_o = mbt_pkg::COORD_W'(out_col_q);
  assign wall_kind_o   = out_kind_q;
  assign opened_o      = out_opened_q;
  assign finished_o    = out_fin_q;

endmodule

`default_nettype wire

// ===== hdl/mbt_visited.sv =====
// visited map: one epoch tag per cell, one write and two registered reads a cycle
// sweeps every tag to zero after reset and on request; uses mbt_pkg
`default_nettype none

module mbt_visited (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire mbt_pkg::vis_req_t            req_i,
  output logic                              clear_busy_o,
  output logic [mbt_pkg::EPOCH_W-1:0]       rd_tag_a_o,
  output logic [mbt_pkg::EPOCH_W-1:0]       rd_tag_b_o
);

  logic [mbt_pkg::EPOCH_W-1:0] mem [mbt_pkg::CELLS];
  logic                        sweep_q;
  logic [mbt_pkg::ADDR_W-1:0]  sweep_idx_q;
  logic [mbt_pkg::EPOCH_W-1:0] rd_a_q;
  logic [mbt_pkg::EPOCH_W-1:0] rd_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q     <= 1'b1;
      sweep_idx_q <= '0;
    end else if (sweep_q) begin
      sweep_idx_q <= sweep_idx_q + 1'b1;
      if (sweep_idx_q == mbt_pkg::ADDR_W'(mbt_pkg::CELLS - 1)) sweep_q <= 1'b0;
    end else if (req_i.clear) begin
      sweep_q     <= 1'b1;
      sweep_idx_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sweep_q) begin
      mem[sweep_idx_q] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_tag;
    end
    if (req_i.rd_en) begin
      rd_a_q <= mem[req_i.rd_addr_a];
      rd_b_q <= mem[req_i.rd_addr_b];
    end
  end

  assign clear_busy_o = sweep_q;
  assign rd_tag_a_o   = rd_a_q;
  assign rd_tag_b_o   = rd_b_q;

endmodule

`default_nettype wire

// ===== hdl/mbt_stack.sv =====
// path stack memory: cell addresses, one write and one registered read a cycle
// uses mbt_pkg
`default_nettype none

module mbt_stack (
  input  wire logic                        clk_i,
  input  wire mbt_pkg::stk_req_t           req_i,
  output logic [mbt_pkg::ADDR_W-1:0]       rd_data_o
);

  logic [mbt_pkg::ADDR_W-1:0] mem [mbt_pkg::CELLS];
  logic [mbt_pkg::ADDR_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// ===== hdl/mbt_mod.sv =====
// serial restoring remainder unit, one dividend bit per cycle
// used for the exit column; uses mbt_pkg
`default_nettype none

module mbt_mod (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mbt_pkg::mod_req_t req_i,
  output mbt_pkg::mod_rsp_t      rsp_o
);

  logic                             busy_q;
  logic                             done_q;
  logic [mbt_pkg::CNT_W-1:0]        cnt_q;
  logic [mbt_pkg::RAND_W-1:0]       dvd_q;
  logic [mbt_pkg::NSZ_W-1:0]        dvs_q;
  logic [mbt_pkg::NSZ_W-1:0]        rem_q;
  logic [mbt_pkg::NSZ_W-1:0]        rem_d;
  logic [mbt_pkg::NSZ_W:0]          trial;

  always_comb begin
    trial = {rem_q, dvd_q[mbt_pkg::RAND_W-1]};
    if (trial >= {1'b0, dvs_q}) begin
      rem_d = mbt_pkg::NSZ_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = mbt_pkg::NSZ_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= mbt_pkg::CNT_W'(mbt_pkg::RAND_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << 1;
      rem_q <= rem_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

// ===== tb/maze_carve_checker.sv =====
// result checker for the maze backtracker: follows the config, input and result channels
// and keeps its own copy of the maze state to work out each result beat in order
// depends on mbt_pkg for sizes, wall kinds and operation codes
module maze_carve_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [mbt_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic                        op_i,
  input  logic [4:0]                  start_column_i,
  input  logic [mbt_pkg::RAND_W-1:0]  choice_random_i,
  input  logic [mbt_pkg::RAND_W-1:0]  exit_random_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [mbt_pkg::COORD_W-1:0] wall_line_i,
  input  logic [mbt_pkg::COORD_W-1:0] wall_column_i,
  input  logic [1:0]                  wall_kind_i,
  input  logic                        opened_i,
  input  logic                        finished_i,
  output int                          mismatches_o,
  output int                          pending_o,
  output int                          checked_o,
  output int                          exits_o,
  output int                          dead_ends_o
);
  import mbt_pkg::*;

  typedef struct packed {
    logic [COORD_W-1:0] line;
    logic [COORD_W-1:0] column;
    wall_kind_e         kind;
    logic               opened;
    logic               finished;
  } wall_beat_t;

  logic              seen [CELLS];
  logic [ADDR_W-1:0] trail [CELLS];
  int                trail_depth;
  int                seen_count;
  logic              maze_done;
  logic [CFG_W-1:0]  grid_reg;
  wall_beat_t        walls_due [$];
  wall_beat_t        oldest;
  int                mismatches;
  int                checked;
  int                exits;
  int                dead_ends;

  function automatic int side_len();
    int n;
    n = int'(grid_reg);
    if (n < 2) n = 2;
    if (n > GRID_MAX) n = GRID_MAX;
    return n;
  endfunction

  function automatic bit unvisited(input int l, input int c, input int n);
    if (l < 0 || c < 0 || l >= n || c >= n) return 1'b0;
    return !seen[l * GRID_MAX + c];
  endfunction

  function automatic void mark_and_push(input int l, input int c);
    int idx;
    idx = l * GRID_MAX + c;
    if (!seen[idx]) begin
      seen[idx] = 1'b1;
      seen_count++;
    end
    if (trail_depth < CELLS) begin
      trail[trail_depth] = ADDR_W'(idx);
      trail_depth++;
    end
  endfunction

  function automatic wall_beat_t advance_maze(input logic op, input logic [4:0] sc,
                                              input logic [RAND_W-1:0] cr,
                                              input logic [RAND_W-1:0] er);
    wall_beat_t w;
    int n, entry_col, cl, cc, k, pick, tl, tc;
    int nl [4];
    int nc [4];
    w = '0;
    n = side_len();
    if (op == OP_START) begin
      foreach (seen[i]) seen[i] = 1'b0;
      trail_depth = 0;
      seen_count = 0;
      maze_done = 1'b0;
      entry_col = (int'(sc) > n - 1) ? n - 1 : int'(sc);
      mark_and_push(0, entry_col);
      w.column = COORD_W'(entry_col);
      w.kind = WK_ENTRY;
      w.opened = 1'b1;
    end else if (!maze_done) begin
      if (seen_count >= n * n) begin
        w.line = COORD_W'(n - 1);
        w.column = COORD_W'(int'(er) % n);
        w.kind = WK_EXIT;
        w.opened = 1'b1;
        maze_done = 1'b1;
        exits++;
      end else begin
        k = 0;
        cl = 0;
        cc = 0;
        // backtrack until the path top has somewhere to go or the path is empty
        while (trail_depth > 0) begin
          cl = int'(trail[trail_depth - 1]) / GRID_MAX;
          cc = int'(trail[trail_depth - 1]) % GRID_MAX;
          k = 0;
          if (unvisited(cl - 1, cc, n)) begin nl[k] = cl - 1; nc[k] = cc; k++; end
          if (unvisited(cl, cc + 1, n)) begin nl[k] = cl; nc[k] = cc + 1; k++; end
          if (unvisited(cl, cc - 1, n)) begin nl[k] = cl; nc[k] = cc - 1; k++; end
          if (unvisited(cl + 1, cc, n)) begin nl[k] = cl + 1; nc[k] = cc; k++; end
          if (k > 0) break;
          trail_depth--;
        end
        if (k > 0) begin
          pick = int'(cr) % k;
          tl = nl[pick];
          tc = nc[pick];
          // the shared wall is named from the upper or left cell
          if (tl < cl) begin
            w.line = COORD_W'(tl);
            w.column = COORD_W'(tc);
            w.kind = WK_BOTTOM;
          end else if (tc > cc) begin
            w.line = COORD_W'(cl);
            w.column = COORD_W'(cc);
            w.kind = WK_RIGHT;
          end else if (tc < cc) begin
            w.line = COORD_W'(tl);
            w.column = COORD_W'(tc);
            w.kind = WK_RIGHT;
          end else begin
            w.line = COORD_W'(cl);
            w.column = COORD_W'(cc);
            w.kind = WK_BOTTOM;
          end
          w.opened = 1'b1;
          mark_and_push(tl, tc);
        end else begin
          dead_ends++;
        end
      end
    end
    w.finished = maze_done;
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (seen[i]) seen[i] = 1'b0;
      trail_depth = 0;
      seen_count = 0;
      maze_done = 1'b0;
      grid_reg = GRID_RESET;
      walls_due.delete();
      mismatches = 0;
      checked = 0;
      exits = 0;
      dead_ends = 0;
      mismatches_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
      exits_o <= 0;
      dead_ends_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        checked++;
        if (walls_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result beat: line %0d column %0d kind %0d opened %0b fin %0b",
                     wall_line_i, wall_column_i, wall_kind_i, opened_i, finished_i);
          end
        end else begin
          oldest = walls_due.pop_front();
          if (oldest.line !== wall_line_i || oldest.column !== wall_column_i ||
              oldest.kind !== wall_kind_i || oldest.opened !== opened_i ||
              oldest.finished !== finished_i) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: expected line %0d column %0d kind %0d opened %0b fin %0b",
                       checked, oldest.line, oldest.column, oldest.kind, oldest.opened,
                       oldest.finished);
              $display("result %0d:      got line %0d column %0d kind %0d opened %0b fin %0b",
                       checked, wall_line_i, wall_column_i, wall_kind_i, opened_i,
                       finished_i);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        grid_reg = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        walls_due.insert(walls_due.size(), advance_maze(op_i, start_column_i,
                                                        choice_random_i, exit_random_i));
      end
      mismatches_o <= mismatches;
      pending_o <= walls_due.size();
      checked_o <= checked;
      exits_o <= exits;
      dead_ends_o <= dead_ends;
    end
  end

endmodule

// ===== tb/maze_backtracker_step_top_tb.sv =====
// testbench top for maze_backtracker_step_top: grid settings and maze beats sent in bursts,
// result side stalled on its own pattern; maze_carve_checker judges every result beat
// depends on mbt_pkg, the block's rtl and tb/maze_carve_checker.sv
module maze_backtracker_step_top_tb;
  import mbt_pkg::*;

  localparam int ITEM_TARGET  = 1950;
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 60;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = 1'b0;
  logic [4:0]         start_column = '0;
  logic [RAND_W-1:0]  choice_random = '0;
  logic [RAND_W-1:0]  exit_random = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COORD_W-1:0] wall_line;
  logic [COORD_W-1:0] wall_column;
  logic [1:0]         wall_kind;
  logic               opened;
  logic               finished;

  int mismatches;
  int pending;
  int checked;
  int exits;
  int dead_ends;
  int items_sent = 0;
  int burst_left = 0;
  int grid_writes = 0;
  bit big_phase = 1'b0;

  always #1 clk = ~clk;

  maze_backtracker_step_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .op_i            (op),
    .start_column_i  (start_column),
    .choice_random_i (choice_random),
    .exit_random_i   (exit_random),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .wall_line_o     (wall_line),
    .wall_column_o   (wall_column),
    .wall_kind_o     (wall_kind),
    .opened_o        (opened),
    .finished_o      (finished)
  );

  maze_carve_checker u_check (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .op_i            (op),
    .start_column_i  (start_column),
    .choice_random_i (choice_random),
    .exit_random_i   (exit_random),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .wall_line_i     (wall_line),
    .wall_column_i   (wall_column),
    .wall_kind_i     (wall_kind),
    .opened_i        (opened),
    .finished_i      (finished),
    .mismatches_o    (mismatches),
    .pending_o       (pending),
    .checked_o       (checked),
    .exits_o         (exits),
    .dead_ends_o     (dead_ends)
  );

  // one input beat; valid stays up across a burst and may drop for a random gap after it
  task automatic send_beat(input logic op_v, input logic [4:0] sc,
                           input logic [RAND_W-1:0] cr, input logic [RAND_W-1:0] er);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    op <= op_v;
    start_column <= sc;
    choice_random <= cr;
    exit_random <= er;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic carve_beat();
    send_beat(OP_CARVE, 5'($urandom_range(0, 31)), RAND_W'($urandom_range(0, 65535)),
              RAND_W'($urandom_range(0, 65535)));
  endtask

  task automatic start_beat();
    send_beat(OP_START, 5'($urandom_range(0, 31)), RAND_W'($urandom_range(0, 65535)),
              RAND_W'($urandom_range(0, 65535)));
  endtask

  // grid size is only written once every result beat is back
  task automatic set_grid(input logic [CFG_W-1:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    grid_writes++;
  endtask

  initial begin
    int roll, n, cells, left;
    bit with_start, partial, big_done;
    logic [CFG_W-1:0] grid_value;
    big_done = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    send_beat(OP_CARVE, 5'd31, 16'hffff, 16'hffff);   // no maze started yet
    set_grid(6'd0);                                   // clamps up to 2
    send_beat(OP_START, 5'd31, 16'h0000, 16'h0000);   // entry column clamps to 1
    send_beat(OP_CARVE, 5'd0, 16'h0000, 16'h0000);
    send_beat(OP_CARVE, 5'd0, 16'hffff, 16'h0000);
    send_beat(OP_CARVE, 5'd0, 16'h5555, 16'h0000);
    send_beat(OP_CARVE, 5'd0, 16'haaaa, 16'hffff);    // exit gap
    send_beat(OP_CARVE, 5'd31, 16'hffff, 16'hffff);   // already finished
    send_beat(OP_START, 5'd0, 16'hffff, 16'hffff);    // restart a finished maze
    send_beat(OP_CARVE, 5'd0, 16'h0000, 16'h0000);
    send_beat(OP_START, 5'd1, 16'h0000, 16'h0000);    // restart mid-maze
    set_grid(6'd4);
    send_beat(OP_START, 5'd31, 16'h1234, 16'h0000);
    set_grid(6'd1);
    send_beat(OP_CARVE, 5'd0, 16'h0000, 16'h0000);    // entry now off the grid, path empties
    send_beat(OP_CARVE, 5'd0, 16'hffff, 16'hffff);
    set_grid(6'd3);
    send_beat(OP_CARVE, 5'd0, 16'h0003, 16'h0000);    // grown grid with no path left
    set_grid(6'd32);
    send_beat(OP_START, 5'd31, 16'h0000, 16'h0000);
    send_beat(OP_CARVE, 5'd0, 16'h0000, 16'h0000);
    send_beat(OP_CARVE, 5'd0, 16'hffff, 16'h0000);
    set_grid(6'd40);
    send_beat(OP_CARVE, 5'd0, 16'h0002, 16'h0000);
    set_grid(6'd2);
    send_beat(OP_CARVE, 5'd0, 16'h0000, 16'hffff);    // shrunk grid already full: exit
    send_beat(OP_CARVE, 5'd0, 16'h0001, 16'h0001);

    // random mazes
    while (items_sent < ITEM_TARGET) begin
      roll = $urandom_range(0, 99);
      with_start = 1'b1;
      partial = 1'b0;
      if (!big_done && items_sent >= 400) begin
        grid_value = 6'd63;                           // clamps to the largest grid
        big_done = 1'b1;
      end else if (roll < 70) begin
        grid_value = CFG_W'($urandom_range(2, 10));
      end else if (roll < 78) begin
        grid_value = CFG_W'($urandom_range(11, 16));
      end else if (roll < 84) begin
        grid_value = CFG_W'($urandom_range(0, 1));
      end else if (roll < 90) begin
        grid_value = CFG_W'($urandom_range(17, 62));
        partial = 1'b1;
      end else begin
        // keep carving the previous maze at a new size
        grid_value = CFG_W'($urandom_range(2, 12));
        with_start = 1'b0;
      end
      set_grid(grid_value);
      n = int'(grid_value);
      if (n < 2) n = 2;
      if (n > GRID_MAX) n = GRID_MAX;
      cells = n * n;
      if (partial) begin
        left = $urandom_range(20, 80);
      end else if (!with_start) begin
        left = $urandom_range(1, cells + 2);
      end else begin
        left = cells + $urandom_range(0, 2);
      end
      big_phase = (grid_value == 6'd63);
      if (with_start) start_beat();
      while (left > 0) begin
        if (!big_phase && $urandom_range(0, 49) == 0) begin
          start_beat();
          if (!partial) left = cells + $urandom_range(0, 2);
        end else begin
          carve_beat();
          left--;
        end
      end
      big_phase = 1'b0;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d input beats over %0d grid size writes, %0d result beats checked",
             items_sent, grid_writes, checked);
    $display("%0d mazes carved through to the exit, %0d carves found nothing left to open",
             exits, dead_ends);
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result side stall patterns, plus one long hold while the big maze is fed
  initial begin
    int span, mode, tick;
    bit held;
    held = 1'b0;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (big_phase && !held) begin
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES) @(negedge clk);
        end
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= (tick % 4 == 0);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
